// File: sv/mfbr_pkg.sv
// ----------------------------------------------------------------------------
// mfbr_pkg
// Types and constants shared by the MSB-first bit reader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mfbr_pkg;

  // Default sizes of the accumulator and of the widest field.
  localparam int unsigned ACCUMULATOR_BITS = 32;
  localparam int unsigned MAX_FIELD_BITS   = 16;

  // Fixed payload widths.
  localparam int unsigned OpBits    = 2;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned CountBits = 5;
  localparam int unsigned OutBits   = 16;
  localparam int unsigned AvailBits = 6;

  // Entries in the queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Request opcodes as they arrive on the port.
  typedef enum logic [OpBits-1:0] {
    OP_PUSH   = 2'd0,
    OP_PEEK   = 2'd1,
    OP_GET    = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_e;

  // Classified request as it travels from front to back.
  typedef struct packed {
    op_e                  op;
    logic [ByteBits-1:0]  byte_val;
    logic [CountBits-1:0] count;     // already saturated
  } item_t;

endpackage

`default_nettype wire

// File: sv/mfbr_if.sv
// ----------------------------------------------------------------------------
// mfbr_if
// Valid/ready channels of the MSB-first bit reader: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfbr_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] byte_in;
  logic [4:0] bit_count;

  modport source (output valid, output op, output byte_in, output bit_count, input ready);
  modport sink   (input valid, input op, input byte_in, input bit_count, output ready);
endinterface

interface mfbr_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] bits_out;
  logic [1:0]  status;
  logic [5:0]  bits_available;

  modport source (output valid, output bits_out, output status, output bits_available,
                  input ready);
  modport sink   (input valid, input bits_out, input status, input bits_available,
                  output ready);
endinterface

`default_nettype wire

// File: sv/msb_first_bit_reader.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// MSB-first bitstream reader: push bytes, peek or get fields of 1 to 16 bits.
// ----------------------------------------------------------------------------
// Usage: send one request per cycle on req_i. A push (op 0) appends byte_in
// below the buffered bits; a peek (op 1) returns the oldest bit_count bits
// right-aligned and keeps them; a get (op 2) returns them and consumes them.
// Every request yields exactly one result on rsp_o, in order, carrying the
// field, a status (0 ok, 1 not enough bits, 2 full and byte dropped) and the
// number of bits still buffered. Counts above MaxFieldBits are clamped; op 3
// does nothing and answers ok. Throughput is one request per clock cycle
// while the result port is not stalled; the execute step in the back end
// owns the accumulator and turns every request around. The accepting edge
// writes a request into the queue; the back end then pops it and loads its
// result into the result register, which it does only while that register
// is free or draining, so a stalled result port delays the result. A
// two-entry queue sits between the decode front end and the execute back
// end, so a stalled result port holds back requests only after that queue
// fills.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_reader
  import mfbr_pkg::*;
#(
  parameter int unsigned AccumulatorBits = ACCUMULATOR_BITS,
  parameter int unsigned MaxFieldBits    = MAX_FIELD_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfbr_req_if.sink   req_i,
  mfbr_rsp_if.source rsp_o
);

  // Decoded request handed from the front end to the queue.
  logic  fq_valid, fq_ready;
  item_t fq_item;

  // Queue head handed to the back end.
  logic  qb_valid, qb_ready;
  item_t qb_item;

  // Decode the opcode and clamp the bit count.
  mfbr_front #(
    .MaxFieldBits (MaxFieldBits)
  ) u_front (
    .req_i        (req_i),
    .push_valid_o (fq_valid),
    .push_ready_i (fq_ready),
    .push_item_o  (fq_item)
  );

  // Hold decoded requests while the back end stalls.
  mfbr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_item_o   (qb_item)
  );

  // Advance the accumulator and register one result per request.
  mfbr_back #(
    .AccumulatorBits (AccumulatorBits),
    .MaxFieldBits    (MaxFieldBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (qb_valid),
    .pop_ready_o (qb_ready),
    .pop_item_i  (qb_item),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// File: sv/mfbr_front.sv
// ----------------------------------------------------------------------------
// mfbr_front
// Accept requests, decode the opcode and saturate the bit count.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbr_front
  import mfbr_pkg::*;
#(
  parameter int unsigned MaxFieldBits = MAX_FIELD_BITS
) (
  mfbr_req_if.sink req_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output item_t    push_item_o
);

  logic [CountBits-1:0] count_sat;

  // Clamp oversized counts to the widest field.
  always_comb begin
    if (req_i.bit_count > CountBits'(MaxFieldBits)) begin
      count_sat = CountBits'(MaxFieldBits);
    end else begin
      count_sat = req_i.bit_count;
    end
  end

  assign push_item_o.op       = op_e'(req_i.op);
  assign push_item_o.byte_val = req_i.byte_in;
  assign push_item_o.count    = count_sat;
  assign push_valid_o         = req_i.valid;
  assign req_i.ready          = push_ready_i;

endmodule

`default_nettype wire

// File: sv/mfbr_queue.sv
// ----------------------------------------------------------------------------
// mfbr_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbr_queue
  import mfbr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  item_t                entry_q [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign push_ready_o = (cnt_q != CntBits'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/mfbr_back.sv
// ----------------------------------------------------------------------------
// mfbr_back
// Execute push, peek and get against the accumulator; register the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbr_back
  import mfbr_pkg::*;
#(
  parameter int unsigned AccumulatorBits = ACCUMULATOR_BITS,
  parameter int unsigned MaxFieldBits    = MAX_FIELD_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  item_t     pop_item_i,
  mfbr_rsp_if.source rsp_o
);

  localparam int unsigned FillW = $clog2(AccumulatorBits + 1);

  logic [AccumulatorBits-1:0] acc_q, acc_d;
  logic [FillW-1:0]           fill_q, fill_d;
  logic                       out_valid_q;
  logic [OutBits-1:0]         out_bits_q, out_bits_d;
  status_e                    out_status_q, out_status_d;
  logic [AvailBits-1:0]       out_avail_q;

  logic                       do_exec;
  logic [FillW-1:0]           count_w;
  logic [FillW-1:0]           rest;
  logic [AccumulatorBits-1:0] shifted;
  logic [MaxFieldBits:0]      one_hot;
  logic [MaxFieldBits:0]      mask_w;
  logic [MaxFieldBits-1:0]    field;
  logic                       room_short;

  // Take the next request whenever the result register is free or draining.
  assign pop_ready_o = !out_valid_q || rsp_o.ready;
  assign do_exec     = pop_valid_i && pop_ready_o;

  assign count_w    = FillW'(pop_item_i.count);
  assign rest       = fill_q - count_w;
  assign shifted    = acc_q >> rest;
  assign one_hot    = (MaxFieldBits + 1)'(1) << pop_item_i.count;
  assign mask_w     = one_hot - 1'b1;
  assign field      = shifted[MaxFieldBits-1:0] & mask_w[MaxFieldBits-1:0];
  assign room_short = ((FillW + 1)'(fill_q) + (FillW + 1)'(ByteBits))
                      > (FillW + 1)'(AccumulatorBits);

  always_comb begin
    acc_d        = acc_q;
    fill_d       = fill_q;
    out_bits_d   = '0;
    out_status_d = STATUS_OK;
    unique case (pop_item_i.op)
      OP_PUSH: begin
        if (room_short) begin
          out_status_d = STATUS_FULL;
        end else begin
          acc_d  = {acc_q[AccumulatorBits-ByteBits-1:0], pop_item_i.byte_val};
          fill_d = fill_q + FillW'(ByteBits);
        end
      end
      OP_PEEK, OP_GET: begin
        if (count_w > fill_q) begin
          out_status_d = STATUS_SHORT;
        end else if (pop_item_i.count != '0) begin
          out_bits_d = OutBits'(field);
          if (pop_item_i.op == OP_GET) begin
            fill_d = rest;
            acc_d  = acc_q & ~({AccumulatorBits{1'b1}} << rest);
          end
        end
      end
      default: begin
        // unused opcode: answer with zeros, leave the state alone
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_exec) begin
        acc_q       <= acc_d;
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_exec) begin
      out_bits_q   <= out_bits_d;
      out_status_q <= out_status_d;
      out_avail_q  <= AvailBits'(fill_d);
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.bits_out       = out_bits_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.bits_available = out_avail_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_msb_first_bit_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_reader
// Self-checking bench for the MSB-first bit reader. A shadow accumulator
// predicts every result as its request is accepted. A checker compares each
// result with the oldest prediction. The run covers directed corner cases,
// then randomized byte streams and field reads, with back-pressure, a
// drain pause and a stall-free tail.
// ----------------------------------------------------------------------------

module tb_msb_first_bit_reader;
  import mfbr_pkg::*;

  localparam int unsigned ClkHalf        = 10;
  localparam int unsigned ResetCycles    = 9;
  localparam int unsigned SettleCycles   = 6;
  localparam int unsigned LongHoldCycles = 120;
  localparam int unsigned PrintLimit     = 30;

  // One result as the block reports it.
  typedef struct packed {
    logic [OutBits-1:0]   bits;
    status_e              status;
    logic [AvailBits-1:0] avail;
  } field_result_t;

  logic clk_i;
  logic rst_ni;

  mfbr_req_if req_if ();
  mfbr_rsp_if rsp_if ();

  msb_first_bit_reader dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the accumulator and its fill level.
  logic [ACCUMULATOR_BITS-1:0] shadow_acc  = '0;
  int unsigned                 shadow_fill = 0;

  // Results predicted but not yet seen, oldest first.
  field_result_t pending_fields[$];

  int unsigned mismatches = 0;
  int unsigned checked    = 0;
  int unsigned n_requests = 0;
  int unsigned n_push     = 0;
  int unsigned n_drop     = 0;
  int unsigned n_field    = 0;
  int unsigned n_short    = 0;
  int unsigned n_noop     = 0;

  // Receiver controls: random idling and one long hold on request.
  bit          idle_en      = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;

  initial clk_i = 1'b0;
  always #ClkHalf clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow accumulator: apply one request and return the result it causes.
  // Pushes shift a byte in below the buffered bits; peeks and gets read the
  // oldest bits, which sit just under the fill level.
  // --------------------------------------------------------------------------
  function automatic field_result_t unpack_step(op_e op, logic [ByteBits-1:0] b,
                                                logic [CountBits-1:0] cnt);
    field_result_t r;
    int unsigned   n;
    int unsigned   rest;
    logic [63:0]   wide;
    r.bits   = '0;
    r.status = STATUS_OK;
    case (op)
      OP_PUSH: begin
        // Drop the byte when fewer than eight bits are free.
        if (shadow_fill + 8 > ACCUMULATOR_BITS) begin
          r.status = STATUS_FULL;
          n_drop++;
        end else begin
          shadow_acc  = {shadow_acc[ACCUMULATOR_BITS-9:0], b};
          shadow_fill += 8;
          n_push++;
        end
      end
      OP_PEEK, OP_GET: begin
        // Clamp oversized counts to the widest field.
        n = (cnt > MAX_FIELD_BITS) ? MAX_FIELD_BITS : cnt;
        if (n > shadow_fill) begin
          r.status = STATUS_SHORT;
          n_short++;
        end else if (n != 0) begin
          rest   = shadow_fill - n;
          wide   = 64'(shadow_acc) >> rest;
          wide   &= (64'd1 << n) - 64'd1;
          r.bits = wide[OutBits-1:0];
          if (op == OP_GET) begin
            shadow_fill = rest;
            shadow_acc  &= ACCUMULATOR_BITS'((64'd1 << rest) - 64'd1);
          end
          n_field++;
        end else begin
          n_noop++;
        end
      end
      default: n_noop++;
    endcase
    r.avail = shadow_fill[AvailBits-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Report one mismatch and count it; stop printing after a while so a
  // broken block cannot flood the log.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < PrintLimit)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h (result %0d)",
               $time, what, got, want, checked);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Send one request. Optionally idle for a random burst first, then hold
  // the request until the block takes it, and predict its result at the
  // accepting edge. Called right after the clock rises.
  // --------------------------------------------------------------------------
  task automatic send_req(op_e op, logic [ByteBits-1:0] b, logic [CountBits-1:0] cnt);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.byte_in   <= b;
    req_if.bit_count <= cnt;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_fields.push_back(unpack_step(op, b, cnt));
    n_requests++;
  endtask

  // --------------------------------------------------------------------------
  // Pick one random request. Most traffic is a well-formed stream: push
  // while there is room, read fields that fit in what is buffered. The rest
  // is noise: the unused opcode, zero and oversized counts, pushes into a
  // nearly full accumulator, and reads that ask for too many bits.
  // --------------------------------------------------------------------------
  task automatic send_random_req();
    int unsigned          pick;
    int unsigned          top;
    op_e                  op;
    logic [ByteBits-1:0]  b;
    logic [CountBits-1:0] cnt;
    pick = $urandom_range(0, 99);
    b    = ByteBits'($urandom);
    cnt  = CountBits'($urandom_range(1, MAX_FIELD_BITS));
    op   = OP_GET;
    top  = (shadow_fill < MAX_FIELD_BITS) ? shadow_fill : MAX_FIELD_BITS;
    if (pick < 88 && ((pick < 45 && shadow_fill + 8 <= ACCUMULATOR_BITS) || top == 0)) begin
      op = OP_PUSH;
    end else if (pick < 88) begin
      op  = (pick < 72) ? OP_GET : OP_PEEK;
      cnt = CountBits'($urandom_range(1, top));
    end else begin
      case ($urandom_range(0, 4))
        0: begin
          op  = OP_UNUSED;
          cnt = CountBits'($urandom_range(0, 31));
        end
        1: op = OP_PUSH;
        2: begin
          op  = $urandom_range(0, 1) ? OP_GET : OP_PEEK;
          cnt = '0;
        end
        3: begin
          op  = $urandom_range(0, 1) ? OP_GET : OP_PEEK;
          cnt = CountBits'($urandom_range(MAX_FIELD_BITS + 1, 31));
        end
        default: begin
          op  = $urandom_range(0, 1) ? OP_GET : OP_PEEK;
          cnt = (top < MAX_FIELD_BITS) ? CountBits'($urandom_range(top + 1, MAX_FIELD_BITS))
                                       : CountBits'($urandom_range(1, 31));
        end
      endcase
    end
    send_req(op, b, cnt);
  endtask

  // Drop valid and hold off until every predicted result has arrived.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_fields.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases: reads from an empty buffer, zero and oversized counts,
  // the unused opcode, a full accumulator, byte extremes, and exact drains.
  task automatic test_directed_corners();
    send_req(OP_PEEK,   8'h00, 5'd1);    // empty: too few bits
    send_req(OP_GET,    8'hFF, 5'd16);   // empty: too few bits
    send_req(OP_GET,    8'h00, 5'd0);    // zero count
    send_req(OP_UNUSED, 8'hFF, 5'd31);   // unused opcode
    send_req(OP_PUSH,   8'hFF, 5'd0);
    send_req(OP_PUSH,   8'h00, 5'd31);
    send_req(OP_PUSH,   8'hA5, 5'd0);
    send_req(OP_PUSH,   8'h5A, 5'd0);
    send_req(OP_PUSH,   8'h3C, 5'd0);    // accumulator full: byte dropped
    send_req(OP_PEEK,   8'h00, 5'd16);
    send_req(OP_PEEK,   8'h00, 5'd31);   // saturates to the widest field
    send_req(OP_GET,    8'h00, 5'd1);
    send_req(OP_GET,    8'h00, 5'd16);
    send_req(OP_PEEK,   8'h00, 5'd0);    // zero count
    send_req(OP_GET,    8'h00, 5'd17);   // saturates, then too few bits
    send_req(OP_GET,    8'h00, 5'd15);   // drains the accumulator exactly
    send_req(OP_GET,    8'h00, 5'd1);    // empty again
    send_req(OP_PUSH,   8'h81, 5'd0);
    send_req(OP_PEEK,   8'h00, 5'd9);    // one bit short
    send_req(OP_GET,    8'h00, 5'd8);
    send_req(OP_PUSH,   8'h00, 5'd0);
    send_req(OP_PUSH,   8'hFF, 5'd0);
    send_req(OP_GET,    8'h00, 5'd16);
    wait_for_results();
  endtask

  // Random stream with idling on both sides.
  task automatic test_random_stream(int unsigned count);
    idle_en = 1'b1;
    repeat (count) send_random_req();
  endtask

  // Hold the result port for a long stretch while requests keep coming, so
  // the internal queue fills and the request port stalls.
  task automatic test_result_backpressure();
    hold_request = 1'b1;
    repeat (60) send_random_req();
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_drain_pause();
    repeat (40) send_random_req();
    wait_for_results();
    repeat (40) send_random_req();
  endtask

  // Full-rate tail: no idling on either side.
  task automatic test_steady_stream(int unsigned count);
    idle_en = 1'b0;
    repeat (count) send_random_req();
  endtask

  // --------------------------------------------------------------------------
  // Result port: drive ready. A long hold requested by a test takes
  // priority; otherwise stall in random bursts while idling is on.
  // --------------------------------------------------------------------------
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(0, 4);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest prediction,
  // field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    field_result_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_fields.size() == 0) begin
        report_mismatch("result with no request pending", rsp_if.bits_out, 0);
      end else begin
        want = pending_fields.pop_front();
        if (rsp_if.bits_out !== want.bits)
          report_mismatch("bits_out", rsp_if.bits_out, want.bits);
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.bits_available !== want.avail)
          report_mismatch("bits_available", rsp_if.bits_available, want.avail);
        checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset once, run the tests in turn, then drain and report.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.op        = OP_PUSH;
    req_if.byte_in   = '0;
    req_if.bit_count = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_stream(550);
    test_result_backpressure();
    test_drain_pause();
    test_steady_stream(430);

    // Let every outstanding result come back, then keep watching for
    // anything unexpected.
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d requests: %0d pushes, %0d dropped bytes, %0d fields read,",
             n_requests, n_push, n_drop, n_field);
    $display("%0d short reads, %0d no-op requests; %0d results checked, %0d mismatches",
             n_short, n_noop, checked, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
